@@ rtl/aabb_build_and_overlap_macros.svh @@
// ----------------------------------------------------------------------------
// aabb_build_and_overlap_macros.svh
// assertion macros of the box build and overlap test block
// ----------------------------------------------------------------------------
`ifndef AABB_BUILD_AND_OVERLAP_MACROS_SVH
`define AABB_BUILD_AND_OVERLAP_MACROS_SVH

`ifndef ASSERT_OFF

// clocked property, held off while reset is asserted
`define AABB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define AABB_NEVER(label, cond, msg) \
	`AABB_ASSERT(label, !(cond), msg)

`else

`define AABB_ASSERT(label, prop, msg)
`define AABB_NEVER(label, cond, msg)

`endif

`endif

@@ rtl/aabb_pkg.sv @@
// ----------------------------------------------------------------------------
// aabb_pkg
// types and constants of the box build and overlap test block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aabb_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
	localparam int QUEUE_DEPTH = 4;

	// request kinds
	localparam logic REQ_POINT = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic                          req_type;
		logic                          first_point;
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] point_z;
		logic signed [COORD_WIDTH-1:0] other_center_x;
		logic signed [COORD_WIDTH-1:0] other_center_y;
		logic signed [COORD_WIDTH-1:0] other_center_z;
		logic        [SIZE_WIDTH-1:0]  other_size_x;
		logic        [SIZE_WIDTH-1:0]  other_size_y;
		logic        [SIZE_WIDTH-1:0]  other_size_z;
	} req_t;

	typedef struct packed {
		logic                   hit;
		logic [COORD_WIDTH-1:0] overlap_x;
		logic [COORD_WIDTH-1:0] overlap_y;
		logic [COORD_WIDTH-1:0] overlap_z;
	} rsp_t;

	// one axis of a queued query: own bounds at query time and the other box bounds
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] own_min;
		logic signed [COORD_WIDTH-1:0] own_max;
		logic signed [COORD_WIDTH:0]   lo;
		logic signed [COORD_WIDTH:0]   hi;
		logic        [SIZE_WIDTH-1:0]  size;
	} axis_t;

	typedef struct packed {
		axis_t x;
		axis_t y;
		axis_t z;
	} query_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

@@ rtl/aabb_front.sv @@
// ----------------------------------------------------------------------------
// aabb_front
// accepts transactions, tracks the own box and turns queries into bounds
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  aabb_pkg::req_t         req,
	input  aabb_pkg::queue_status_t status,
	output logic                   push,
	output aabb_pkg::query_t       push_data
);
	import aabb_pkg::*;

	logic signed [COORD_WIDTH-1:0] own_min_q [3];
	logic signed [COORD_WIDTH-1:0] own_max_q [3];
	logic signed [COORD_WIDTH-1:0] pt [3];
	logic                          accept;

	function automatic axis_t make_axis(
		input logic signed [COORD_WIDTH-1:0] amin,
		input logic signed [COORD_WIDTH-1:0] amax,
		input logic signed [COORD_WIDTH-1:0] c,
		input logic        [SIZE_WIDTH-1:0]  s
	);
		axis_t                       r;
		logic signed [COORD_WIDTH:0] c_e;
		logic        [COORD_WIDTH:0] half_e;
		logic        [SIZE_WIDTH-1:0] up;
		// low bound drops floor(size / 2), high bound adds the rest
		c_e    = {c[COORD_WIDTH-1], c};
		half_e = {3'b000, s[SIZE_WIDTH-1:1]};
		up     = {1'b0, s[SIZE_WIDTH-1:1]} + {{(SIZE_WIDTH-1){1'b0}}, s[0]};
		r.own_min = amin;
		r.own_max = amax;
		r.lo      = c_e - $signed(half_e);
		r.hi      = c_e + $signed({2'b00, up});
		r.size    = s;
		return r;
	endfunction

	assign req_stall = status.full;
	assign accept    = req_valid && !status.full;
	assign push      = accept && (req.req_type == REQ_QUERY);

	always_comb begin
		pt[0] = req.point_x;
		pt[1] = req.point_y;
		pt[2] = req.point_z;
		push_data.x = make_axis(own_min_q[0], own_max_q[0], req.other_center_x,
			req.other_size_x);
		push_data.y = make_axis(own_min_q[1], own_max_q[1], req.other_center_y,
			req.other_size_y);
		push_data.z = make_axis(own_min_q[2], own_max_q[2], req.other_center_z,
			req.other_size_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				own_min_q[k] <= '0;
				own_max_q[k] <= '0;
			end
		end else if (accept && (req.req_type == REQ_POINT)) begin
			for (int k = 0; k < 3; k++) begin
				if (req.first_point) begin
					own_min_q[k] <= pt[k];
					own_max_q[k] <= pt[k];
				end else begin
					if (pt[k] > own_max_q[k]) own_max_q[k] <= pt[k];
					if (pt[k] < own_min_q[k]) own_min_q[k] <= pt[k];
				end
			end
		end
	end

endmodule

@@ rtl/aabb_queue.sv @@
// ----------------------------------------------------------------------------
// aabb_queue
// short first-in first-out queue of prepared queries between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aabb_build_and_overlap_macros.svh"

module aabb_queue #(
	parameter int DEPTH = aabb_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  aabb_pkg::query_t        push_data,
	input  logic                    pop,
	output aabb_pkg::query_t        head,
	output aabb_pkg::queue_status_t status
);
	import aabb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	query_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head         = mem_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`AABB_NEVER(a_push_full, push && status.full && !pop, "push into a full queue")
	`AABB_NEVER(a_pop_empty, pop && status.empty, "pop from an empty queue")
	`AABB_ASSERT(a_push_lands, push |=> !status.empty, "pushed transaction lost")
	`AABB_NEVER(a_count_range, count_q > CNT_W'(DEPTH), "queue count beyond depth")

endmodule

@@ rtl/aabb_back.sv @@
// ----------------------------------------------------------------------------
// aabb_back
// per-axis overlap depths and hit flag, held in the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  aabb_pkg::query_t        head,
	input  aabb_pkg::queue_status_t status,
	output logic                    pop,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output aabb_pkg::rsp_t          rsp
);
	import aabb_pkg::*;

	logic                   rsp_valid_q;
	rsp_t                   rsp_q;
	logic [COORD_WIDTH-1:0] ov_x;
	logic [COORD_WIDTH-1:0] ov_y;
	logic [COORD_WIDTH-1:0] ov_z;

	function automatic logic [COORD_WIDTH-1:0] axis_overlap(input axis_t ax);
		logic signed [COORD_WIDTH+1:0] a_e;
		logic signed [COORD_WIDTH+1:0] b_e;
		logic signed [COORD_WIDTH+1:0] lo_e;
		logic signed [COORD_WIDTH+1:0] hi_e;
		logic signed [COORD_WIDTH+1:0] s_e;
		logic signed [COORD_WIDTH+1:0] d;
		logic signed [COORD_WIDTH+1:0] e;
		logic        [COORD_WIDTH-1:0] r;
		a_e  = {{2{ax.own_min[COORD_WIDTH-1]}}, ax.own_min};
		b_e  = {{2{ax.own_max[COORD_WIDTH-1]}}, ax.own_max};
		lo_e = {ax.lo[COORD_WIDTH], ax.lo};
		hi_e = {ax.hi[COORD_WIDTH], ax.hi};
		s_e  = {3'b000, ax.size};
		d    = b_e - lo_e;
		e    = hi_e - a_e;
		// low bound inside own box, else high bound inside, else nothing
		if ((a_e < lo_e) && (lo_e < b_e)) begin
			r = (d > s_e) ? s_e[COORD_WIDTH-1:0] : d[COORD_WIDTH-1:0];
		end else if ((a_e < hi_e) && (hi_e < b_e)) begin
			r = e[COORD_WIDTH-1:0];
		end else begin
			r = '0;
		end
		return r;
	endfunction

	assign pop       = !status.empty && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		ov_x = axis_overlap(head.x);
		ov_y = axis_overlap(head.y);
		ov_z = axis_overlap(head.z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!rsp_valid_q || !rsp_stall) begin
			rsp_valid_q <= !status.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q.overlap_x <= ov_x;
			rsp_q.overlap_y <= ov_y;
			rsp_q.overlap_z <= ov_z;
			rsp_q.hit       <= (ov_x != '0) && (ov_y != '0) && (ov_z != '0);
		end
	end

endmodule

@@ rtl/aabb_build_and_overlap.sv @@
// A query transaction is written into the query queue on acceptance, then loaded into the
// output register when the back end pops it; points give no result.
// Throughput: one transaction per cycle; input stalls only while the QUEUE_DEPTH-entry
// query queue is full, set by how fast the result side drains the output register.
// Reset: asynchronous, clears the own box to zero on all axes, empties the queue
// and drops the output valid.
// ----------------------------------------------------------------------------
// aabb_build_and_overlap
// axis-aligned box build from points and overlap test against query boxes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_build_and_overlap #(
	parameter int QUEUE_DEPTH = aabb_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  aabb_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output aabb_pkg::rsp_t rsp
);
	import aabb_pkg::*;

	queue_status_t status;
	logic          push;
	logic          pop;
	query_t        push_data;
	query_t        head;

	aabb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.status    (status),
		.push      (push),
		.push_data (push_data)
	);

	aabb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	aabb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (status),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ sim/aabb_build_and_overlap_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_build_and_overlap_tb
// self-checking bench for the box build and overlap test block: a short table
// of directed points and queries, then random point sets each followed by
// queries near the box, with random noise items; every query result is
// compared field by field against a fixed answer from the table or against
// a bench-side model of the box

module aabb_build_and_overlap_tb;

	import aabb_pkg::*;

	localparam int COORD_MAX = 8388607;
	localparam int COORD_MIN = -8388608;
	localparam int SIZE_MAX  = 8388607;
	localparam int RANDOM_ITEMS = 450;

	typedef struct {
		bit   given;
		rsp_t rsp;
	} fixed_answer_t;

	typedef struct {
		req_t item;
		bit   given;
		rsp_t rsp;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// bench copy of the own box
	logic signed [COORD_WIDTH-1:0] box_lo[3] = '{0, 0, 0};
	logic signed [COORD_WIDTH-1:0] box_hi[3] = '{0, 0, 0};

	rsp_t          due_results[$];
	fixed_answer_t fixed_answers[$];
	table_row_t    directed_rows[$];
	int            mismatches = 0;
	int            items_sent = 0;
	int            burst_left = 0;
	logic [7:0]    stall_phase = '0;

	aabb_build_and_overlap uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("aabb_build_and_overlap_tb: errors");
		$finish;
	end

	function automatic longint axis_depth(longint own_lo, longint own_hi, longint centre,
			longint extent);
		longint half, lo, hi;
		half = extent / 2;
		lo   = centre - half;
		hi   = centre + (extent - half);
		if (own_lo < lo && lo < own_hi)
			return (own_hi - lo > extent) ? extent : own_hi - lo;
		if (own_lo < hi && hi < own_hi)
			return hi - own_lo;
		// includes the case where the other box encloses ours
		return 0;
	endfunction

	// updates the box on points; returns 1 and the depths on queries
	function automatic bit box_step(input req_t r, output rsp_t depth);
		logic signed [COORD_WIDTH-1:0] p[3];
		logic signed [COORD_WIDTH-1:0] c[3];
		logic        [SIZE_WIDTH-1:0]  s[3];
		longint                        ov[3];
		p = '{r.point_x, r.point_y, r.point_z};
		c = '{r.other_center_x, r.other_center_y, r.other_center_z};
		s = '{r.other_size_x, r.other_size_y, r.other_size_z};
		depth = '0;
		if (r.req_type == REQ_POINT) begin
			for (int k = 0; k < 3; k++) begin
				if (r.first_point) begin
					box_lo[k] = p[k];
					box_hi[k] = p[k];
				end else begin
					if (p[k] > box_hi[k])
						box_hi[k] = p[k];
					if (p[k] < box_lo[k])
						box_lo[k] = p[k];
				end
			end
			return 1'b0;
		end
		for (int k = 0; k < 3; k++)
			ov[k] = axis_depth(box_lo[k], box_hi[k], c[k], s[k]);
		depth.hit       = (ov[0] > 0) && (ov[1] > 0) && (ov[2] > 0);
		depth.overlap_x = COORD_WIDTH'(ov[0]);
		depth.overlap_y = COORD_WIDTH'(ov[1]);
		depth.overlap_z = COORD_WIDTH'(ov[2]);
		return 1'b1;
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got)
			report($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
	endtask

	// transaction monitor: prediction on request acceptance, checking on result acceptance
	always @(posedge clk) begin : monitor
		fixed_answer_t ans;
		rsp_t          want;
		bit            gives;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				ans   = fixed_answers.pop_front();
				gives = box_step(req, want);
				if (gives)
					due_results.push_back(ans.given ? ans.rsp : want);
			end
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					report("result with no query outstanding");
				end else begin
					want = due_results.pop_front();
					check_field("hit", want.hit, rsp.hit);
					check_field("overlap_x", want.overlap_x, rsp.overlap_x);
					check_field("overlap_y", want.overlap_y, rsp.overlap_y);
					check_field("overlap_z", want.overlap_z, rsp.overlap_z);
				end
			end
		end
	end

	// result side back-pressure: free, light, heavy and long stretched stalls
	always @(posedge clk) begin
		stall_phase <= stall_phase + 8'd1;
		case (stall_phase[7:6])
			2'd0: rsp_stall <= 1'b0;
			2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2'd2: rsp_stall <= ($urandom_range(0, 1) == 0);
			default: rsp_stall <= (stall_phase[3:0] < 4'd11);
		endcase
	end

	task automatic send_item(input req_t item, input bit given, input rsp_t answer);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 20);
		end
		burst_left--;
		fixed_answers.push_back('{given, answer});
		req       <= item;
		req_valid <= 1'b1;
		items_sent++;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	function automatic req_t random_req();
		logic [223:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return req_t'(bits[$bits(req_t)-1:0]);
	endfunction

	function automatic req_t point_item(input bit first, input int x, input int y, input int z);
		req_t r;
		r             = '0;
		r.req_type    = REQ_POINT;
		r.first_point = first;
		r.point_x     = COORD_WIDTH'(x);
		r.point_y     = COORD_WIDTH'(y);
		r.point_z     = COORD_WIDTH'(z);
		return r;
	endfunction

	function automatic req_t query_item(input int cx, input int cy, input int cz,
			input int sx, input int sy, input int sz);
		req_t r;
		r                = '0;
		r.req_type       = REQ_QUERY;
		r.other_center_x = COORD_WIDTH'(cx);
		r.other_center_y = COORD_WIDTH'(cy);
		r.other_center_z = COORD_WIDTH'(cz);
		r.other_size_x   = SIZE_WIDTH'(sx);
		r.other_size_y   = SIZE_WIDTH'(sy);
		r.other_size_z   = SIZE_WIDTH'(sz);
		return r;
	endfunction

	function automatic rsp_t depths(input bit h, input int x, input int y, input int z);
		rsp_t d;
		d.hit       = h;
		d.overlap_x = COORD_WIDTH'(x);
		d.overlap_y = COORD_WIDTH'(y);
		d.overlap_z = COORD_WIDTH'(z);
		return d;
	endfunction

	function automatic void add_row(input req_t item, input bit given, input rsp_t answer);
		directed_rows.push_back('{item, given, answer});
	endfunction

	function automatic int unsigned random_size(input int span);
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, SIZE_MAX);
		return $urandom_range(0, 2 * span);
	endfunction

	// point sets with random content, each followed by queries around the set, mixed with random noise items
	task automatic random_phase(input int target);
		req_t r;
		int   base[3];
		int   span, npts, nq;
		while (items_sent < target) begin
			if ($urandom_range(0, 6) == 0) begin
				send_item(random_req(), 1'b0, '0);
			end else begin
				span = 1 << $urandom_range(0, 21);
				foreach (base[k])
					base[k] = int'($urandom_range(0, 24'hFFFFFF)) - 32'sh800000;
				npts = $urandom_range(1, 6);
				nq   = $urandom_range(1, 5);
				for (int i = 0; i < npts; i++) begin
					r             = random_req();
					r.req_type    = REQ_POINT;
					// now and then leave the restart off so the set grows the old box
					r.first_point = (i == 0) && ($urandom_range(0, 4) != 0);
					r.point_x     = COORD_WIDTH'(base[0] + $urandom_range(0, span));
					r.point_y     = COORD_WIDTH'(base[1] + $urandom_range(0, span));
					r.point_z     = COORD_WIDTH'(base[2] + $urandom_range(0, span));
					send_item(r, 1'b0, '0);
				end
				for (int i = 0; i < nq; i++) begin
					r                = random_req();
					r.req_type       = REQ_QUERY;
					r.other_center_x = COORD_WIDTH'(base[0] + $urandom_range(0, 3 * span) - span);
					r.other_center_y = COORD_WIDTH'(base[1] + $urandom_range(0, 3 * span) - span);
					r.other_center_z = COORD_WIDTH'(base[2] + $urandom_range(0, 3 * span) - span);
					r.other_size_x   = SIZE_WIDTH'(random_size(span));
					r.other_size_y   = SIZE_WIDTH'(random_size(span));
					r.other_size_z   = SIZE_WIDTH'(random_size(span));
					send_item(r, 1'b0, '0);
				end
			end
		end
	endtask

	initial begin : stimulus
		req_t tmp;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;

		// box still at the origin after reset, so nothing can overlap
		add_row(query_item(0, 0, 0, 100, 100, 100), 1'b1, depths(0, 0, 0, 0));
		// point with no restart grows the reset box
		add_row(point_item(0, 5, -5, 7), 1'b0, '0);
		add_row(query_item(2, -2, 2, 2, 2, 2), 1'b0, '0);
		add_row(point_item(1, -1000, -1000, -1000), 1'b0, '0);
		add_row(point_item(0, 1000, 1000, 1000), 1'b0, '0);
		add_row(query_item(0, 0, 0, 100, 100, 100), 1'b1, depths(1, 100, 100, 100));
		// other box encloses ours
		add_row(query_item(0, 0, 0, 4000, 4000, 4000), 1'b1, depths(0, 0, 0, 0));
		add_row(query_item(0, 0, 0, 0, 0, 0), 1'b1, depths(0, 0, 0, 0));
		// only the high bound falls inside
		add_row(query_item(-1000, -1000, -1000, 200, 200, 200), 1'b1,
			depths(1, 100, 100, 100));
		// low bound sits exactly on own min
		add_row(query_item(-950, -950, -950, 100, 100, 100), 1'b0, '0);
		add_row(query_item(900, 900, 900, 400, 400, 400), 1'b0, '0);
		// miss on one axis, depths still reported on the others
		add_row(query_item(0, 5000, 0, 100, 100, 100), 1'b1, depths(0, 100, 0, 100));
		add_row(query_item(1000, 1000, 1000, 1, 1, 1), 1'b0, '0);
		add_row(point_item(1, COORD_MAX, COORD_MAX, COORD_MAX), 1'b0, '0);
		add_row(point_item(0, COORD_MIN, COORD_MIN, COORD_MIN), 1'b0, '0);
		add_row(query_item(0, 0, 0, SIZE_MAX, SIZE_MAX, SIZE_MAX), 1'b1,
			depths(1, SIZE_MAX, SIZE_MAX, SIZE_MAX));
		add_row(query_item(COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, SIZE_MAX),
			1'b0, '0);
		add_row(query_item(COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX),
			1'b0, '0);
		// restart flag and point fields must be ignored on a query
		tmp             = query_item(0, -1, 1, 2, 3, 4);
		tmp.first_point = 1'b1;
		tmp.point_x     = '1;
		tmp.point_y     = '1;
		tmp.point_z     = '1;
		add_row(tmp, 1'b0, '0);
		// query fields must be ignored on a point
		tmp                = point_item(1, 3, -3, 3);
		tmp.other_center_x = '1;
		tmp.other_center_y = '1;
		tmp.other_center_z = '1;
		tmp.other_size_x   = '1;
		tmp.other_size_y   = '1;
		tmp.other_size_z   = '1;
		add_row(tmp, 1'b0, '0);
		// single point box has no inside
		add_row(query_item(3, -3, 3, 10, 10, 10), 1'b1, depths(0, 0, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].given, directed_rows[i].rsp);
		random_phase(directed_rows.size() + RANDOM_ITEMS);
		req_valid <= 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("aabb_build_and_overlap_tb: clean");
		else
			$display("aabb_build_and_overlap_tb: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/aabb_pkg.sv
rtl/aabb_front.sv
rtl/aabb_queue.sv
rtl/aabb_back.sv
rtl/aabb_build_and_overlap.sv
sim/aabb_build_and_overlap_tb.sv
